// ===== hw/rtl/kwl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the keyword token lexer.
// Used by kwl_front, kwl_queue, keyword_token_lexer and the port checker.
package kwl_pkg;

    localparam int KwCount    = 14;
    localparam int KwTextMax  = 7;
    localparam int QueueDepth = 8;
    localparam int QueueBits  = 3;

    localparam logic [5:0] KIND_IDENT   = 6'd14;
    localparam logic [5:0] KIND_NUMBER  = 6'd15;
    localparam logic [5:0] KIND_EQ      = 6'd16;
    localparam logic [5:0] KIND_NE      = 6'd17;
    localparam logic [5:0] KIND_LE      = 6'd18;
    localparam logic [5:0] KIND_GE      = 6'd19;
    localparam logic [5:0] KIND_PLUS    = 6'd20;
    localparam logic [5:0] KIND_MINUS   = 6'd21;
    localparam logic [5:0] KIND_STAR    = 6'd22;
    localparam logic [5:0] KIND_DIV     = 6'd23;
    localparam logic [5:0] KIND_MOD     = 6'd24;
    localparam logic [5:0] KIND_ASSIGN  = 6'd25;
    localparam logic [5:0] KIND_LT      = 6'd26;
    localparam logic [5:0] KIND_GT      = 6'd27;
    localparam logic [5:0] KIND_LPAREN  = 6'd28;
    localparam logic [5:0] KIND_RPAREN  = 6'd29;
    localparam logic [5:0] KIND_LBRACE  = 6'd30;
    localparam logic [5:0] KIND_RBRACE  = 6'd31;
    localparam logic [5:0] KIND_SEMI    = 6'd32;
    localparam logic [5:0] KIND_COLON   = 6'd33;
    localparam logic [5:0] KIND_COMMA   = 6'd34;
    localparam logic [5:0] KIND_UNKNOWN = 6'd35;
    localparam logic [5:0] KIND_EOF     = 6'd36;

    localparam logic [19:0] LINE_MAX  = 20'hFFFFF;
    localparam logic [15:0] LEN_MAX   = 16'hFFFF;
    localparam logic [23:0] START_MAX = 24'hFFFFFF;

    // Keyword spellings, first character in the lowest byte.
    localparam logic [55:0] KW_TEXT [KwCount] = '{
        56'h00000000726176,     // var
        56'h00000000006669,     // if
        56'h00000065736c65,     // else
        56'h0000656c696877,     // while
        56'h00000064616572,     // read
        56'h00006574697277,     // write
        56'h6e6c6574697277,     // writeln
        56'h72656765746e69,     // integer
        56'h6e61656c6f6f62,     // boolean
        56'h00000065757274,     // true
        56'h000065736c6166,     // false
        56'h000000646e61,       // and
        56'h0000000000726f,     // or
        56'h0000000746f6e       // not
    };
    localparam logic [2:0] KW_LEN [KwCount] = '{
        3'd3, 3'd2, 3'd4, 3'd5, 3'd4, 3'd5, 3'd7,
        3'd7, 3'd7, 3'd4, 3'd5, 3'd3, 3'd2, 3'd3
    };

    typedef struct packed {
        logic [5:0]  kind;
        logic [23:0] start;
        logic [15:0] len;
        logic [19:0] line;
        logic        last;
    } token_t;

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            8'h2b:   k = KIND_PLUS;
            8'h2d:   k = KIND_MINUS;
            8'h2a:   k = KIND_STAR;
            8'h2f:   k = KIND_DIV;
            8'h25:   k = KIND_MOD;
            8'h3d:   k = KIND_ASSIGN;
            8'h3c:   k = KIND_LT;
            8'h3e:   k = KIND_GT;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h7b:   k = KIND_LBRACE;
            8'h7d:   k = KIND_RBRACE;
            8'h3b:   k = KIND_SEMI;
            8'h3a:   k = KIND_COLON;
            8'h2c:   k = KIND_COMMA;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

// ===== hw/rtl/kwl_front.sv =====
`timescale 1ns / 1ps
// Front end of the lexer: scan state machine that classifies each byte and
// produces up to three finished tokens per byte. Depends on kwl_pkg.
module kwl_front #(
    parameter int KEYWORD_MAX_LEN = 7,
    parameter int OFFSET_BITS     = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          source_byte,
    input  logic                final_byte,
    output kwl_pkg::token_t     toks [3],
    output logic [1:0]          tok_count
);

    localparam int IdxBits = $clog2(KEYWORD_MAX_LEN);
    localparam int ExtBits = (OFFSET_BITS > 24) ? OFFSET_BITS : 24;

    typedef enum logic [6:0] {
        MODE_IDLE       = 7'b0000001,
        MODE_IDENT      = 7'b0000010,
        MODE_NUMBER     = 7'b0000100,
        MODE_HELD       = 7'b0001000,
        MODE_LINE       = 7'b0010000,
        MODE_BLOCK      = 7'b0100000,
        MODE_BLOCK_STAR = 7'b1000000
    } mode_t;

    mode_t                              mode_reg, mode_next;
    logic [7:0]                         held_reg, held_next;
    logic [KEYWORD_MAX_LEN-1:0][7:0]    kbuf_reg, kbuf_next;
    logic [15:0]                        len_reg, len_next;
    logic [OFFSET_BITS-1:0]             tstart_reg, tstart_next;
    logic [19:0]                        tline_reg, tline_next;
    logic [OFFSET_BITS-1:0]             offs_reg, offs_next;
    logic [19:0]                        lcnt_reg, lcnt_next;

    function automatic logic [23:0] out_start(input logic [OFFSET_BITS-1:0] v);
        logic [ExtBits-1:0] e;
        e = ExtBits'(v);
        return (e > ExtBits'(kwl_pkg::START_MAX)) ? kwl_pkg::START_MAX : e[23:0];
    endfunction

    function automatic logic [7:0] lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    endfunction

    function automatic logic [5:0] word_kind(input logic [15:0] len,
                                             input logic [KEYWORD_MAX_LEN-1:0][7:0] b);
        logic [5:0] k;
        logic       hit;
        k = kwl_pkg::KIND_IDENT;
        if (len <= 16'(KEYWORD_MAX_LEN)) begin
            for (int w = kwl_pkg::KwCount - 1; w >= 0; w--) begin
                hit = (16'(kwl_pkg::KW_LEN[w]) == len);
                for (int i = 0; i < kwl_pkg::KwTextMax; i++) begin
                    if (i < int'(kwl_pkg::KW_LEN[w]) && b[i] != kwl_pkg::KW_TEXT[w][8*i +: 8])
                        hit = 1'b0;
                end
                if (hit)
                    k = 6'(w);
            end
        end
        return k;
    endfunction

    logic       is_alpha, is_digit, is_space, used;
    logic [1:0] n;

    assign is_alpha = (source_byte >= 8'h61 && source_byte <= 8'h7a) ||
                      (source_byte >= 8'h41 && source_byte <= 8'h5a);
    assign is_digit = source_byte >= 8'h30 && source_byte <= 8'h39;
    assign is_space = source_byte == 8'h20 || (source_byte >= 8'h09 && source_byte <= 8'h0d);

    always_comb
    begin
        mode_next   = mode_reg;
        held_next   = held_reg;
        kbuf_next   = kbuf_reg;
        len_next    = len_reg;
        tstart_next = tstart_reg;
        tline_next  = tline_reg;
        offs_next   = offs_reg;
        lcnt_next   = lcnt_reg;
        toks[0]     = '0;
        toks[1]     = '0;
        toks[2]     = '0;
        n           = 2'd0;
        used        = 1'b1;

        case (mode_reg)
            MODE_IDENT:
            begin
                if (is_alpha || is_digit || source_byte == 8'h5f)
                begin
                    if (len_reg < 16'(KEYWORD_MAX_LEN))
                        kbuf_next[len_reg[IdxBits-1:0]] = lower(source_byte);
                    if (len_reg != kwl_pkg::LEN_MAX)
                        len_next = len_reg + 16'd1;
                end
                else
                begin
                    toks[n] = '{word_kind(len_reg, kbuf_reg), out_start(tstart_reg),
                                len_reg, tline_reg, 1'b0};
                    n = n + 2'd1;
                    mode_next = MODE_IDLE;
                    used = 1'b0;
                end
            end
            MODE_NUMBER:
            begin
                if (is_digit)
                begin
                    if (len_reg != kwl_pkg::LEN_MAX)
                        len_next = len_reg + 16'd1;
                end
                else
                begin
                    toks[n] = '{kwl_pkg::KIND_NUMBER, out_start(tstart_reg),
                                len_reg, tline_reg, 1'b0};
                    n = n + 2'd1;
                    mode_next = MODE_IDLE;
                    used = 1'b0;
                end
            end
            MODE_HELD:
            begin
                if (held_reg == 8'h2f && source_byte == 8'h2f)
                    mode_next = MODE_LINE;
                else if (held_reg == 8'h2f && source_byte == 8'h2a)
                    mode_next = MODE_BLOCK;
                else if (source_byte == 8'h3d && held_reg != 8'h2f)
                begin
                    toks[n] = '{(held_reg == 8'h3d) ? kwl_pkg::KIND_EQ :
                                (held_reg == 8'h21) ? kwl_pkg::KIND_NE :
                                (held_reg == 8'h3c) ? kwl_pkg::KIND_LE : kwl_pkg::KIND_GE,
                                out_start(tstart_reg), 16'd2, tline_reg, 1'b0};
                    n = n + 2'd1;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    toks[n] = '{kwl_pkg::single_kind(held_reg), out_start(tstart_reg),
                                16'd1, tline_reg, 1'b0};
                    n = n + 2'd1;
                    mode_next = MODE_IDLE;
                    used = 1'b0;
                end
            end
            MODE_LINE:
            begin
                if (source_byte == 8'h0a)
                begin
                    mode_next = MODE_IDLE;
                    used = 1'b0;
                end
            end
            MODE_BLOCK:
            begin
                if (source_byte == 8'h2a)
                    mode_next = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR:
            begin
                if (source_byte == 8'h2f)
                    mode_next = MODE_IDLE;
                else if (source_byte != 8'h2a)
                    mode_next = MODE_BLOCK;
            end
            default:
            begin
                mode_next = MODE_IDLE;
                used = 1'b0;
            end
        endcase

        // A non-space byte not used by the running token starts a new one.
        if (!used && !is_space)
        begin
            if (is_alpha || source_byte == 8'h5f || is_digit ||
                source_byte == 8'h2f || source_byte == 8'h3d || source_byte == 8'h21 ||
                source_byte == 8'h3c || source_byte == 8'h3e)
            begin
                tstart_next = offs_reg;
                tline_next  = lcnt_reg;
                len_next    = 16'd1;
                if (is_digit)
                    mode_next = MODE_NUMBER;
                else if (is_alpha || source_byte == 8'h5f)
                begin
                    mode_next    = MODE_IDENT;
                    kbuf_next[0] = lower(source_byte);
                end
                else
                begin
                    mode_next = MODE_HELD;
                    held_next = source_byte;
                end
            end
            else
            begin
                toks[n] = '{kwl_pkg::single_kind(source_byte), out_start(offs_reg),
                            16'd1, lcnt_reg, 1'b0};
                n = n + 2'd1;
            end
        end

        if (source_byte == 8'h0a && lcnt_reg != kwl_pkg::LINE_MAX)
            lcnt_next = lcnt_reg + 20'd1;
        if (offs_reg != '1)
            offs_next = offs_reg + 1'b1;

        if (final_byte)
        begin
            case (mode_next)
                MODE_IDENT:
                begin
                    toks[n] = '{word_kind(len_next, kbuf_next), out_start(tstart_next),
                                len_next, tline_next, 1'b0};
                    n = n + 2'd1;
                end
                MODE_NUMBER:
                begin
                    toks[n] = '{kwl_pkg::KIND_NUMBER, out_start(tstart_next),
                                len_next, tline_next, 1'b0};
                    n = n + 2'd1;
                end
                MODE_HELD:
                begin
                    toks[n] = '{kwl_pkg::single_kind(held_next), out_start(tstart_next),
                                16'd1, tline_next, 1'b0};
                    n = n + 2'd1;
                end
                default:
                begin
                end
            endcase
            toks[n] = '{kwl_pkg::KIND_EOF, out_start(offs_next), 16'd0, lcnt_next, 1'b0};
            n = n + 2'd1;
            mode_next   = MODE_IDLE;
            held_next   = 8'd0;
            len_next    = 16'd0;
            tstart_next = '0;
            tline_next  = 20'd1;
            offs_next   = '0;
            lcnt_next   = 20'd1;
        end

        if (n != 2'd0)
            toks[n - 2'd1].last = 1'b1;
    end

    assign tok_count = accept ? n : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            held_reg   <= 8'd0;
            len_reg    <= 16'd0;
            tstart_reg <= '0;
            tline_reg  <= 20'd1;
            offs_reg   <= '0;
            lcnt_reg   <= 20'd1;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            held_reg   <= held_next;
            len_reg    <= len_next;
            tstart_reg <= tstart_next;
            tline_reg  <= tline_next;
            offs_reg   <= offs_next;
            lcnt_reg   <= lcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            kbuf_reg <= kbuf_next;
    end

endmodule

// ===== hw/rtl/kwl_queue.sv =====
`timescale 1ns / 1ps
// Token queue between the scanner and the output port: takes up to three
// tokens per cycle and hands out one per transfer. Depends on kwl_pkg.
module kwl_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  kwl_pkg::token_t push_toks [3],
    input  logic [1:0]      push_count,
    output logic            room,
    output logic            out_valid,
    input  logic            out_ready,
    output kwl_pkg::token_t out_tok
);

    kwl_pkg::token_t                   mem [kwl_pkg::QueueDepth];
    logic [kwl_pkg::QueueBits-1:0]     wr_reg, wr_next, rd_reg, rd_next;
    logic [kwl_pkg::QueueBits:0]       cnt_reg, cnt_next;
    logic                              pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = cnt_reg != '0;
    assign out_tok   = mem[rd_reg];
    // Room for the worst case of three tokens from one byte.
    assign room      = cnt_reg <= (kwl_pkg::QueueBits + 1)'(kwl_pkg::QueueDepth - 3);

    assign wr_next  = wr_reg + kwl_pkg::QueueBits'(push_count);
    assign rd_next  = rd_reg + kwl_pkg::QueueBits'(pop);
    assign cnt_next = cnt_reg + (kwl_pkg::QueueBits + 1)'(push_count)
                              - (kwl_pkg::QueueBits + 1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) < push_count)
                mem[wr_reg + kwl_pkg::QueueBits'(i)] <= push_toks[i];
        end
    end

endmodule

// ===== hw/rtl/keyword_token_lexer.sv =====
`timescale 1ns / 1ps
// Tokens are written into the queue when the byte that ends them is accepted.
// Throughput: one byte per cycle while the output drains one token per cycle;
// a byte that ends three tokens needs three output transfers, set by the queue.
// Reset (rst_n low, asynchronous) clears the scanner and empties the queue.
// Depends on kwl_pkg, kwl_front and kwl_queue.
module keyword_token_lexer #(
    parameter int KEYWORD_MAX_LEN = 7,
    parameter int OFFSET_BITS     = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // source_byte
    input  logic        s_axis_tlast,   // final_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // start_offset[23:0], token_length[39:24],
                                        // line_number[59:40], zero fill above
    output logic [5:0]  m_axis_tuser,   // token_kind
    output logic        m_axis_tlast    // last token caused by one input byte
);

    kwl_pkg::token_t toks [3];
    kwl_pkg::token_t out_tok;
    logic [1:0]      tok_count;
    logic            room;
    logic            accept;

    // The scanner only takes a byte while the queue can absorb every token
    // that byte could finish, so the front never has to stall mid-byte.
    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && s_axis_tready;

    kwl_front #(
        .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
        .OFFSET_BITS     (OFFSET_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .source_byte (s_axis_tdata),
        .final_byte  (s_axis_tlast),
        .toks        (toks),
        .tok_count   (tok_count)
    );

    // The queue is the back end: it holds finished tokens and feeds the
    // output port one transfer at a time.
    kwl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_toks  (toks),
        .push_count (tok_count),
        .room       (room),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_tok    (out_tok)
    );

    assign m_axis_tdata = {4'd0, out_tok.line, out_tok.len, out_tok.start};
    assign m_axis_tuser = out_tok.kind;
    assign m_axis_tlast = out_tok.last;

endmodule

// ===== hw/rtl/kwl_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for keyword_token_lexer, attached with a bind statement.
// Depends on kwl_pkg.
module kwl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [5:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // A token offered on the output stays offered until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output token dropped while stalled");

    // The end-of-source token has zero length.
    a_eof_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == kwl_pkg::KIND_EOF |-> m_axis_tdata[39:24] == 16'd0)
        else $error("eof token with nonzero length");

    // The end-of-source token is always the last one of its byte.
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == kwl_pkg::KIND_EOF |-> m_axis_tlast)
        else $error("eof token not marked last");

    // Only eof tokens have zero length, and line numbers start at one.
    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[39:24] != 16'd0 || m_axis_tuser == kwl_pkg::KIND_EOF)
                          && m_axis_tdata[59:40] != 20'd0)
        else $error("token fields out of range");

endmodule

bind keyword_token_lexer kwl_checker u_kwl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for keyword_token_lexer: streams source bytes in and
// checks every token against an internal lexer model. Depends on kwl_pkg.
module testbench;

    // Scanner modes of the model.
    typedef enum int {MD_IDLE, MD_IDENT, MD_NUMBER, MD_HELD, MD_LINE, MD_BLOCK,
                      MD_BLOCK_STAR} scan_mode_e;

    // Holds the lexer model state and the queue of tokens still to come.
    class token_board;
        kwl_pkg::token_t pending[$];
        scan_mode_e      mode;
        logic [7:0]      held;
        logic [7:0]      word[7];
        int unsigned     lex_len;
        int unsigned     tok_start;
        int unsigned     tok_line;
        int unsigned     offset;
        int unsigned     line_cnt;
        kwl_pkg::token_t step_out[$];
        int              mismatches;
        int              tokens_seen;

        function void clear();
            mode = MD_IDLE;
            held = 0;
            lex_len = 0;
            tok_start = 0;
            tok_line = 1;
            offset = 0;
            line_cnt = 1;
        endfunction

        function void emit_tok(logic [5:0] k, int unsigned s, int unsigned l,
                               int unsigned ln);
            kwl_pkg::token_t t;
            if (step_out.size() >= 3) return;
            t.kind  = k;
            t.start = (s > kwl_pkg::START_MAX) ? kwl_pkg::START_MAX : s[23:0];
            t.len   = l[15:0];
            t.line  = ln[19:0];
            t.last  = 1'b0;
            step_out.insert(step_out.size(), t);
        endfunction

        function logic [5:0] classify_word();
            logic [55:0] txt;
            if (lex_len > 7) return kwl_pkg::KIND_IDENT;
            for (int k = 0; k < kwl_pkg::KwCount; k++)
            begin
                if (kwl_pkg::KW_LEN[k] != lex_len) continue;
                txt = kwl_pkg::KW_TEXT[k];
                begin
                    bit ok;
                    ok = 1;
                    for (int i = 0; i < lex_len; i++)
                        if (word[i] != txt[8*i +: 8]) ok = 0;
                    if (ok) return k[5:0];
                end
            end
            return kwl_pkg::KIND_IDENT;
        endfunction

        function logic [5:0] op_kind(logic [7:0] c);
            case (c)
                "+": return kwl_pkg::KIND_PLUS;
                "-": return kwl_pkg::KIND_MINUS;
                "*": return kwl_pkg::KIND_STAR;
                "/": return kwl_pkg::KIND_DIV;
                "%": return kwl_pkg::KIND_MOD;
                "=": return kwl_pkg::KIND_ASSIGN;
                "<": return kwl_pkg::KIND_LT;
                ">": return kwl_pkg::KIND_GT;
                "(": return kwl_pkg::KIND_LPAREN;
                ")": return kwl_pkg::KIND_RPAREN;
                "{": return kwl_pkg::KIND_LBRACE;
                "}": return kwl_pkg::KIND_RBRACE;
                ";": return kwl_pkg::KIND_SEMI;
                ":": return kwl_pkg::KIND_COLON;
                ",": return kwl_pkg::KIND_COMMA;
                default: return kwl_pkg::KIND_UNKNOWN;
            endcase
        endfunction

        function void flush();
            if (mode == MD_IDENT)
                emit_tok(classify_word(), tok_start, lex_len, tok_line);
            else if (mode == MD_NUMBER)
                emit_tok(kwl_pkg::KIND_NUMBER, tok_start, lex_len, tok_line);
            else if (mode == MD_HELD)
                emit_tok(op_kind(held), tok_start, 1, tok_line);
            if (mode <= MD_HELD) mode = MD_IDLE;
        endfunction

        function bit is_alpha(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function logic [7:0] lower(logic [7:0] c);
            return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        endfunction

        // Notes one accepted source byte and queues the tokens it causes.
        function void note_byte(logic [7:0] c, logic fin);
            int unsigned off, ln;
            bit used;
            off = offset;
            ln = line_cnt;
            used = 1;
            step_out.delete();
            case (mode)
                MD_IDENT:
                    if (is_alpha(c) || is_digit(c) || c == "_")
                    begin
                        if (lex_len < 7) word[lex_len] = lower(c);
                        if (lex_len < kwl_pkg::LEN_MAX) lex_len++;
                    end
                    else
                    begin
                        flush();
                        used = 0;
                    end
                MD_NUMBER:
                    if (is_digit(c))
                    begin
                        if (lex_len < kwl_pkg::LEN_MAX) lex_len++;
                    end
                    else
                    begin
                        flush();
                        used = 0;
                    end
                MD_HELD:
                    if (held == "/" && c == "/") mode = MD_LINE;
                    else if (held == "/" && c == "*") mode = MD_BLOCK;
                    else if (c == "=" && held != "/")
                    begin
                        emit_tok(held == "=" ? kwl_pkg::KIND_EQ :
                                 held == "!" ? kwl_pkg::KIND_NE :
                                 held == "<" ? kwl_pkg::KIND_LE : kwl_pkg::KIND_GE,
                                 tok_start, 2, tok_line);
                        mode = MD_IDLE;
                    end
                    else
                    begin
                        flush();
                        used = 0;
                    end
                MD_LINE:
                    if (c == 8'h0a)
                    begin
                        mode = MD_IDLE;
                        used = 0;
                    end
                MD_BLOCK:
                    if (c == "*") mode = MD_BLOCK_STAR;
                MD_BLOCK_STAR:
                    if (c == "/") mode = MD_IDLE;
                    else if (c != "*") mode = MD_BLOCK;
                default:
                begin
                    mode = MD_IDLE;
                    used = 0;
                end
            endcase
            if (!used && !(c == " " || (c >= 9 && c <= 13)))
            begin
                if (is_alpha(c) || c == "_" || is_digit(c))
                begin
                    mode = is_digit(c) ? MD_NUMBER : MD_IDENT;
                    tok_start = off;
                    tok_line = ln;
                    lex_len = 1;
                    word[0] = lower(c);
                end
                else if (c == "/" || c == "=" || c == "!" || c == "<" || c == ">")
                begin
                    mode = MD_HELD;
                    tok_start = off;
                    tok_line = ln;
                    lex_len = 1;
                    held = c;
                end
                else
                    emit_tok(op_kind(c), off, 1, ln);
            end
            if (c == 8'h0a && line_cnt < kwl_pkg::LINE_MAX) line_cnt++;
            if (offset < kwl_pkg::START_MAX) offset++;
            if (fin)
            begin
                flush();
                emit_tok(kwl_pkg::KIND_EOF, offset, 0, line_cnt);
                clear();
            end
            if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
            foreach (step_out[i]) pending.insert(pending.size(), step_out[i]);
        endfunction

        // Compares one accepted token with the oldest expectation.
        function void check_token(kwl_pkg::token_t got);
            kwl_pkg::token_t exp;
            tokens_seen++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected token %p", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp)
            begin
                mismatches++;
                if (mismatches <= 10) $display("token mismatch: expected %p got %p", exp, got);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [5:0]  m_axis_tuser;
    logic        m_axis_tlast;

    keyword_token_lexer dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    token_board  board;
    int unsigned cycles;
    bit          calm;        // no idling on either side while set
    bit          hold_off;    // receiver stalls while set
    int          bytes_sent;
    logic [7:0]  src[$];      // byte stream still to send
    logic        src_fin[$];

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 200000)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus a forced long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !hold_off && (calm || $urandom_range(99) >= 37);
    end

    always @(posedge clk)
    begin
        kwl_pkg::token_t t;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            t.kind  = m_axis_tuser;
            t.start = m_axis_tdata[23:0];
            t.len   = m_axis_tdata[39:24];
            t.line  = m_axis_tdata[59:40];
            t.last  = m_axis_tlast;
            board.check_token(t);
        end
    end

    task automatic add_text(string s, bit fin);
        for (int i = 0; i < s.len(); i++)
        begin
            src.insert(src.size(), s[i]);
            src_fin.insert(src_fin.size(), fin && i == s.len() - 1);
        end
    endtask

    // Sends every queued byte, idling at random between transfers. A byte
    // that is offered stays on the bus until it is taken.
    task automatic send_all();
        bit took;
        while (src.size() > 0)
        begin
            @(posedge clk);
            took = s_axis_tvalid && s_axis_tready;
            if (took)
            begin
                board.note_byte(s_axis_tdata, s_axis_tlast);
                bytes_sent++;
                void'(src.pop_front());
                void'(src_fin.pop_front());
            end
            if (!s_axis_tvalid || took)
            begin
                if (src.size() > 0 && (calm || $urandom_range(99) >= 37))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= src[0];
                    s_axis_tlast  <= src_fin[0];
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    endtask

    function automatic string random_piece();
        string pool[] = '{"var", "IF", "Else", "while", "read", "write", "WriteLn",
            "integer", "boolean", "true", "false", "and", "or", "not", "_x9",
            "abcdefgh", "writelnx", "0", "12345", "==", "!=", "<=", ">=", "=", "<",
            ">", "!", "/", "+", "-", "*", "%", "(", ")", "{", "}", ";", ":", ",",
            " ", "\n", "\t", "// cmt\n", "/* b * **/", "a1", "$", "\r"};
        return pool[$urandom_range(pool.size() - 1)];
    endfunction

    initial
    begin
        string s;
        board = new();
        board.clear();
        board.mismatches = 0;
        board.tokens_seen = 0;
        bytes_sent = 0;
        calm = 0;
        hold_off = 0;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tlast = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;

        // Directed: keywords, operators, held characters, odd bytes, comments.
        add_text("Var x1 := 0 writeln WRITELN integerz", 0);
        add_text("==!=<=>=!<>=/ 7\n", 0);
        src.insert(src.size(), 8'h00); src_fin.insert(src_fin.size(), 1'b0);
        src.insert(src.size(), 8'hff); src_fin.insert(src_fin.size(), 1'b0);
        src.insert(src.size(), 8'h80); src_fin.insert(src_fin.size(), 1'b0);
        add_text("a//c\nb/*x*/c", 1);
        add_text("<", 1);                 // held character flushed at the end
        add_text("/* open", 1);           // unterminated block comment
        send_all();

        // Random sources: mostly well-formed pieces, some raw noise bytes.
        for (int n = 0; n < 12; n++)
        begin
            s = "";
            for (int p = 0; p < $urandom_range(8, 2); p++) s = {s, random_piece()};
            add_text(s, 0);
            for (int r = 0; r < 2; r++)
            begin
                src.insert(src.size(), 8'($urandom_range(255)));
                src_fin.insert(src_fin.size(), 1'b0);
            end
            add_text(random_piece(), 1);
            calm = (n == 5);
            if (n == 8)
            begin
                // Long receiver stall while the sender keeps offering bytes.
                fork
                    begin
                        hold_off = 1;
                        repeat (300) @(posedge clk);
                        hold_off = 0;
                    end
                join_none
            end
            send_all();
        end
        calm = 0;

        @(posedge clk);
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Sent %0d source bytes and checked %0d tokens across keywords,",
                 bytes_sent, board.tokens_seen);
        $display("operators, comments, held characters, odd bytes and end-of-source.");
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== keyword_token_lexer.f =====
hw/rtl/kwl_pkg.sv
hw/rtl/kwl_front.sv
hw/rtl/kwl_queue.sv
hw/rtl/keyword_token_lexer.sv
hw/rtl/kwl_checker.sv
verif/testbench.sv
